/* rtl/mrst_pkg.sv */
// ----------------------------------------------------------------------------
// mrst_pkg: shared types and constants of the modular range-sum tree
// Field widths, the prime modulus, opcode codes and the modular add used
// by the tree core and its port checker.
// ----------------------------------------------------------------------------
package mrst_pkg;

  localparam int POS_W = 11;
  localparam int VAL_W = 30;

  localparam logic [VAL_W-1:0] PRIME = VAL_W'(1000000007);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [VAL_W-1:0] val_t;

  // Add two values below 2*PRIME in total and fold the result below PRIME
  function automatic val_t mod_add(input val_t a, input val_t b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

/* rtl/mrst_ram.sv */
// ----------------------------------------------------------------------------
// mrst_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mrst_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/modular_range_sum_tree_core.sv */
// ----------------------------------------------------------------------------
// modular_range_sum_tree_core: segment tree with point add and range sum
// Keeps per-node sums modulo 1000000007 in one RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready. opcode OP_ADD adds add_value
//   (folded modulo the prime) at position; OP_QUERY sums range_low to
//   range_high. Only queries answer, on rsp_valid/rsp_ready with range_sum.
//   leaf_count is written through cfg_we/cfg_wdata; the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   One request is worked at a time; req_ready is high only when idle.
//   An add walks from the root toward its leaf, at each level a RAM read,
//   then a modular add and write back. A query visits up to about 4 nodes
//   per level, with an extra RAM read step for every fully covered node.
//   Empty queries skip the walk and answer with a zero sum.
//   After reset the node RAM is cleared one entry per cycle, all 2*MAX_LEAVES
//   entries, during which req_ready stays low; cfg writes are taken.
//   A finished result sits in the output register; while the receiver
//   stalls, further adds are still taken, and the next query waits for the
//   output register to free up before it is delivered.
// ----------------------------------------------------------------------------
module modular_range_sum_tree_core
  import mrst_pkg::*;
#(
  parameter int MAX_LEAVES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_we,
  input  logic [POS_W-1:0] cfg_wdata,
  // request channel
  input  logic             req_valid,
  output logic             req_ready,
  input  logic             opcode,
  input  logic [POS_W-1:0] position,
  input  logic [VAL_W-1:0] add_value,
  input  logic [POS_W-1:0] range_low,
  input  logic [POS_W-1:0] range_high,
  // response channel
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [VAL_W-1:0] range_sum
);

  localparam int DEPTH     = 2 * MAX_LEAVES;
  localparam int AW        = $clog2(DEPTH);
  localparam int NODE_W    = AW + 1;
  localparam int STK_AW    = $clog2($clog2(MAX_LEAVES) + 2);
  localparam int STK_DEPTH = 2 ** STK_AW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_Q_VISIT,
    S_Q_ACC,
    S_Q_DONE
  } state_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  pos_t                leaf_count;
  pos_t                lo;
  pos_t                hi;
  logic [NODE_W-1:0]   node;
  pos_t                pos;
  pos_t                qlo;
  pos_t                qhi;
  val_t                val;
  val_t                acc;
  logic [STK_AW:0]     sp;
  pos_t                stk_lo   [STK_DEPTH];
  pos_t                stk_hi   [STK_DEPTH];
  logic [NODE_W-1:0]   stk_node [STK_DEPTH];

  // RAM ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  val_t                ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  val_t                ram_rdata;

  // Shared modular adder
  val_t                mod_a;
  val_t                mod_b;
  val_t                mod_sum;

  // Derived values
  pos_t                n_eff;
  pos_t                pos_clip;
  pos_t                qlo_clip;
  pos_t                qhi_clip;
  logic [POS_W:0]      lohi_sum;
  pos_t                mid;
  pos_t                mid_p1;
  logic [NODE_W-1:0]   node_left;
  logic [NODE_W-1:0]   node_right;
  logic                out_of_store;
  logic                covered;
  logic                skip_node;
  logic                stk_empty;
  logic [STK_AW-1:0]   top_idx;
  logic [STK_AW-1:0]   push_idx;

  assign req_ready = (state == S_IDLE);

  // Clip the configured leaf count to the tree capacity
  always_comb begin
    if (32'(leaf_count) > 32'(MAX_LEAVES)) begin
      n_eff = POS_W'(MAX_LEAVES);
    end else begin
      n_eff = leaf_count;
    end
  end

  // Clip position and query range to the tree
  always_comb begin
    pos_clip = position;
    if (pos_clip == '0) begin
      pos_clip = POS_W'(1);
    end
    if (pos_clip > n_eff) begin
      pos_clip = n_eff;
    end
    qlo_clip = (range_low == '0) ? POS_W'(1) : range_low;
    qhi_clip = (range_high > n_eff) ? n_eff : range_high;
  end

  // Split point and children of the current node
  assign lohi_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid        = lohi_sum[POS_W:1];
  assign mid_p1     = mid + POS_W'(1);
  assign node_left  = {node[NODE_W-2:0], 1'b0};
  assign node_right = {node[NODE_W-2:0], 1'b1};

  // Classify the node under visit
  assign out_of_store = (node >= NODE_W'(DEPTH));
  assign covered      = (qlo <= lo) && (hi <= qhi);
  assign skip_node    = out_of_store || (qlo > hi) || (qhi < lo) || (lo == hi);

  // Pending-subtree stack pointers
  assign stk_empty = (sp == '0);
  assign top_idx   = STK_AW'(sp - 1'b1);
  assign push_idx  = sp[STK_AW-1:0];

  // Operand select for the shared modular adder
  always_comb begin
    unique case (state)
      S_ADD_WR: begin
        mod_a = ram_rdata;
        mod_b = val;
      end
      S_Q_ACC: begin
        mod_a = acc;
        mod_b = ram_rdata;
      end
      default: begin
        mod_a = add_value;
        mod_b = '0;
      end
    endcase
  end

  assign mod_sum = mod_add(mod_a, mod_b);

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node[AW-1:0];
    ram_wdata = mod_sum;
    ram_re    = 1'b0;
    ram_raddr = node[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_ADD_RD: begin
        ram_re = 1'b1;
      end
      S_ADD_WR: begin
        ram_we = 1'b1;
      end
      S_Q_VISIT: begin
        ram_re = covered && !out_of_store;
      end
      default: begin
      end
    endcase
  end

  mrst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= POS_W'(1024);
    end else if (cfg_we) begin
      leaf_count <= cfg_wdata;
    end
  end

  // Sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      sp        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the response once taken, unless a new one replaces it
      if (rsp_valid && rsp_ready && (state != S_Q_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        // sweep the node RAM to zero
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        // take a request and set up the walk from the root
        S_IDLE: begin
          if (req_valid) begin
            lo   <= POS_W'(1);
            hi   <= n_eff;
            node <= NODE_W'(1);
            sp   <= '0;
            acc  <= '0;
            pos  <= pos_clip;
            val  <= mod_sum;
            qlo  <= qlo_clip;
            qhi  <= qhi_clip;
            if (opcode == OP_ADD) begin
              if (n_eff != '0) begin
                state <= S_ADD_RD;
              end
            end else if ((n_eff == '0) || (qlo_clip > qhi_clip)) begin
              state <= S_Q_DONE;
            end else begin
              state <= S_Q_VISIT;
            end
          end
        end

        S_ADD_RD: begin
          state <= S_ADD_WR;
        end

        // write back the node and descend toward the leaf
        S_ADD_WR: begin
          if (lo == hi) begin
            state <= S_IDLE;
          end else begin
            if (pos <= mid) begin
              hi   <= mid;
              node <= node_left;
              state <= (node_left >= NODE_W'(DEPTH)) ? S_IDLE : S_ADD_RD;
            end else begin
              lo   <= mid_p1;
              node <= node_right;
              state <= (node_right >= NODE_W'(DEPTH)) ? S_IDLE : S_ADD_RD;
            end
          end
        end

        // visit one node: read it, skip it, or split it
        S_Q_VISIT: begin
          if (covered && !out_of_store) begin
            state <= S_Q_ACC;
          end else if (skip_node) begin
            if (stk_empty) begin
              state <= S_Q_DONE;
            end else begin
              lo   <= stk_lo[top_idx];
              hi   <= stk_hi[top_idx];
              node <= stk_node[top_idx];
              sp   <= sp - 1'b1;
            end
          end else begin
            stk_lo[push_idx]   <= mid_p1;
            stk_hi[push_idx]   <= hi;
            stk_node[push_idx] <= node_right;
            sp                 <= sp + 1'b1;
            hi                 <= mid;
            node               <= node_left;
          end
        end

        // accumulate a covered node and resume from the stack
        S_Q_ACC: begin
          acc <= mod_sum;
          if (stk_empty) begin
            state <= S_Q_DONE;
          end else begin
            lo    <= stk_lo[top_idx];
            hi    <= stk_hi[top_idx];
            node  <= stk_node[top_idx];
            sp    <= sp - 1'b1;
            state <= S_Q_VISIT;
          end
        end

        // hold the sum until the output register is free
        S_Q_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            range_sum <= acc;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/mrst_checker.sv */
// ----------------------------------------------------------------------------
// mrst_checker: port-level checks for the modular range-sum tree
// Watches the request and response channels of the tree core over time.
// ----------------------------------------------------------------------------
module mrst_checker
  import mrst_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             opcode,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [VAL_W-1:0] range_sum
);

  // Hold a stalled response steady
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(range_sum))
    else $error("stalled response changed");

  // Every delivered sum is a reduced residue
  a_rsp_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (range_sum < PRIME))
    else $error("response sum not reduced modulo the prime");

  // One request at a time: busy right after an accepted query
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (opcode == OP_QUERY) |=> !req_ready)
    else $error("request taken while previous one in flight");

  // A new response is only produced while the sequencer is busy
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response appeared without a request in work");

  // Reset starts the clearing sweep with no response pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("block not quiet after reset");

endmodule

bind modular_range_sum_tree_core mrst_checker u_mrst_checker (.*);
